// ----- rtl/mcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared types, codes and the byte-wise CRC-32 step for the frame deframer.
// ----------------------------------------------------------------------------
package mcfd_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // statistics counter select codes
  localparam logic [1:0] CNT_FRAMES  = 2'd0;
  localparam logic [1:0] CNT_RESYNCS = 2'd1;
  localparam logic [1:0] CNT_DISCARD = 2'd2;
  localparam logic [1:0] CNT_CRCFAIL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LIM = 2'd2;

  localparam logic [5:0] PAYLOAD_LIM_RST = 6'd46;

  // header layout
  localparam int OFS_VERSION = 2;
  localparam int OFS_TYPE    = 3;
  localparam int OFS_FLAGS   = 4;
  localparam int OFS_SEQ     = 6;
  localparam int OFS_LEN     = 10;
  localparam int CRC_BYTES   = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CW    = 3;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINIT,
    ST_SRCH,
    ST_TAIL,
    ST_TAIL2,
    ST_FOUND,
    ST_HDR,
    ST_CHK,
    ST_BODY,
    ST_CMPR,
    ST_EMIT,
    ST_NEXT,
    ST_COMP
  } st_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [5:0] limit;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic [1:0] counter_select;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [31:0] sequence_res;
    logic [5:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] counter_value;
  } res_t;

  // one byte of the reflected CRC-32
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/mcfd_front.sv -----
// ----------------------------------------------------------------------------
// mcfd_front
// Input side: accepts beats, decodes the op and holds them in a short queue.
// ----------------------------------------------------------------------------
module mcfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        data_byte_i,
  input  logic [1:0]        counter_select_i,
  output logic              cmd_valid_o,
  output mcfd_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  mcfd_pkg::cmd_t q_q [2];
  mcfd_pkg::cmd_t q_d [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  mcfd_pkg::cmd_t in_cmd;

  // classify the incoming beat
  always_comb begin
    in_cmd.op             = mcfd_pkg::op_e'(op_i);
    in_cmd.data_byte      = data_byte_i;
    in_cmd.counter_select = counter_select_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  // queue pointers and storage
  always_comb begin
    q_d   = q_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      q_d[wr_q] = in_cmd;
      wr_d      = ~wr_q;
    end
    if (rd_en) begin
      rd_d = ~rd_q;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

// ----- rtl/mcfd_outq.sv -----
// ----------------------------------------------------------------------------
// mcfd_outq
// Result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
module mcfd_outq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  mcfd_pkg::res_t             res_i,
  output logic [mcfd_pkg::OQ_CW-1:0] free_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output mcfd_pkg::res_t             res_o
);

  localparam int PTRW = $clog2(mcfd_pkg::OQ_DEPTH);

  mcfd_pkg::res_t              mem_q [mcfd_pkg::OQ_DEPTH];
  logic [PTRW-1:0]             wr_q, wr_d, rd_q, rd_d;
  logic [mcfd_pkg::OQ_CW-1:0]  cnt_q, cnt_d;
  logic                        do_pop;

  assign empty_o = (cnt_q == '0);
  assign free_o  = mcfd_pkg::OQ_CW'(mcfd_pkg::OQ_DEPTH) - cnt_q;
  assign res_o   = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = push_i ? wr_q + PTRW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PTRW'(1) : rd_q;
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + mcfd_pkg::OQ_CW'(1);
      2'b01:   cnt_d = cnt_q - mcfd_pkg::OQ_CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

// ----- rtl/mcfd_engine.sv -----
// ----------------------------------------------------------------------------
// mcfd_engine
// Back end: frame buffer memory, magic hunt, header/CRC check, emission.
// ----------------------------------------------------------------------------
module mcfd_engine #(
  parameter int BUFFER_BYTES = 64,
  parameter int HEADER_BYTES = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mcfd_pkg::cfg_t             cfg_i,
  input  logic                       cmd_valid_i,
  input  mcfd_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       res_push_o,
  output mcfd_pkg::res_t             res_o,
  input  logic [mcfd_pkg::OQ_CW-1:0] res_free_i
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] HDR_S  = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] BUF_S  = SW'(BUFFER_BYTES);
  localparam logic [SW-1:0] CRCB_S = SW'(mcfd_pkg::CRC_BYTES);

  mcfd_pkg::st_e state_q, state_d;

  logic [PW-1:0] fill_q, fill_d, off_q, off_d, start_q, start_d;
  logic [PW-1:0] rp_q, rp_d, di_q, di_d, rd_addr_q, rd_addr_d;
  logic          counted_q, counted_d, rd_vld_q, rd_vld_d, pv_vld_q, pv_vld_d;
  logic [7:0]    pv_q, pv_d, ver_q, ver_d, typ_q, typ_d, flg_q, flg_d;
  logic [31:0]   seq_q, seq_d, plen_q, plen_d, crc_q, crc_d, crx_q, crx_d;
  logic [31:0]   frames_q, frames_d, resync_q, resync_d;
  logic [31:0]   discard_q, discard_d, crcfail_q, crcfail_d;

  // frame buffer memory
  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  // shared conditions
  logic          pair_hit, scan_done, hdr_last, len_bad, short_hdr, short_frame;
  logic          body_last, crc_ok, emit_last, next_done, keep;
  logic [5:0]    plen6;
  logic [SW-1:0] avail, frame_len, next_off, tail_lim;

  assign plen6       = plen_q[5:0];
  assign avail       = SW'(fill_q) - SW'(start_q);
  assign frame_len   = HDR_S + SW'(plen6) + CRCB_S;
  assign next_off    = SW'(start_q) + frame_len;
  assign pair_hit    = rd_vld_q && pv_vld_q && (pv_q == cfg_i.sync_first)
                       && (rdata_q == cfg_i.sync_second);
  assign scan_done   = !rd_vld_q && (rp_q >= fill_q);
  assign hdr_last    = rd_vld_q && (di_q == PW'(HEADER_BYTES - 1));
  assign len_bad     = (plen_q > {26'd0, cfg_i.limit})
                       || (({1'b0, plen_q} + 33'(HEADER_BYTES + mcfd_pkg::CRC_BYTES))
                           > 33'(BUFFER_BYTES));
  assign short_hdr   = avail < HDR_S;
  assign short_frame = avail < frame_len;
  assign body_last   = rd_vld_q && (SW'(di_q) == frame_len - SW'(1));
  assign crc_ok      = (crx_q == ~crc_q);
  assign emit_last   = rd_vld_q && ((SW'(di_q) + SW'(1)) == SW'(plen6));
  assign next_done   = next_off >= SW'(fill_q);
  assign keep        = (rdata_q == cfg_i.sync_first);
  assign tail_lim    = SW'(off_q) + SW'(keep);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcfd_pkg::ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == mcfd_pkg::OP_DATA)) state_d = mcfd_pkg::ST_SINIT;
      end
      mcfd_pkg::ST_SINIT: state_d = mcfd_pkg::ST_SRCH;
      mcfd_pkg::ST_SRCH: begin
        if (pair_hit)       state_d = mcfd_pkg::ST_FOUND;
        else if (scan_done) state_d = mcfd_pkg::ST_TAIL;
      end
      mcfd_pkg::ST_TAIL: begin
        state_d = (fill_q != '0) ? mcfd_pkg::ST_TAIL2 : mcfd_pkg::ST_IDLE;
      end
      mcfd_pkg::ST_TAIL2: state_d = mcfd_pkg::ST_IDLE;
      mcfd_pkg::ST_FOUND: begin
        state_d = short_hdr ? mcfd_pkg::ST_COMP : mcfd_pkg::ST_HDR;
      end
      mcfd_pkg::ST_HDR: begin
        if (hdr_last) state_d = mcfd_pkg::ST_CHK;
      end
      mcfd_pkg::ST_CHK: begin
        if (len_bad)          state_d = mcfd_pkg::ST_SINIT;
        else if (short_frame) state_d = mcfd_pkg::ST_COMP;
        else                  state_d = mcfd_pkg::ST_BODY;
      end
      mcfd_pkg::ST_BODY: begin
        if (body_last) state_d = mcfd_pkg::ST_CMPR;
      end
      mcfd_pkg::ST_CMPR: begin
        state_d = crc_ok ? mcfd_pkg::ST_EMIT : mcfd_pkg::ST_SINIT;
      end
      mcfd_pkg::ST_EMIT: begin
        if (plen6 == '0) begin
          if (res_free_i != '0) state_d = mcfd_pkg::ST_NEXT;
        end else if (emit_last) begin
          state_d = mcfd_pkg::ST_NEXT;
        end
      end
      mcfd_pkg::ST_NEXT: begin
        state_d = next_done ? mcfd_pkg::ST_IDLE : mcfd_pkg::ST_SINIT;
      end
      mcfd_pkg::ST_COMP: begin
        if (scan_done) state_d = mcfd_pkg::ST_IDLE;
      end
      default: state_d = mcfd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_d = fill_q;  off_d = off_q;  start_d = start_q;  counted_d = counted_q;
    rp_d = rp_q;  di_d = di_q;  rd_addr_d = rd_addr_q;  rd_vld_d = 1'b0;
    pv_d = pv_q;  pv_vld_d = pv_vld_q;
    ver_d = ver_q;  typ_d = typ_q;  flg_d = flg_q;  seq_d = seq_q;
    plen_d = plen_q;  crc_d = crc_q;  crx_d = crx_q;
    frames_d = frames_q;  resync_d = resync_q;
    discard_d = discard_q;  crcfail_d = crcfail_q;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = rp_q[AW-1:0];
    cmd_pop_o = 1'b0;  res_push_o = 1'b0;  res_o = '0;

    case (state_q)
      // take one command
      mcfd_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            mcfd_pkg::OP_DATA: begin
              cmd_pop_o = 1'b1;
              if (fill_q < PW'(BUFFER_BYTES)) begin
                mem_we = 1'b1;
                mem_wa = fill_q[AW-1:0];
                mem_wd = cmd_i.data_byte;
                fill_d = fill_q + PW'(1);
              end
              off_d     = '0;
              counted_d = 1'b0;
            end
            mcfd_pkg::OP_FLUSH: begin
              cmd_pop_o = 1'b1;
              fill_d    = '0;
            end
            mcfd_pkg::OP_READ: begin
              if (res_free_i != '0) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o.kind = 1'b1;
                res_o.last = 1'b1;
                case (cmd_i.counter_select)
                  mcfd_pkg::CNT_FRAMES:  res_o.counter_value = frames_q;
                  mcfd_pkg::CNT_RESYNCS: res_o.counter_value = resync_q;
                  mcfd_pkg::CNT_DISCARD: res_o.counter_value = discard_q;
                  default:               res_o.counter_value = crcfail_q;
                endcase
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
              frames_d  = '0;
              resync_d  = '0;
              discard_d = '0;
              crcfail_d = '0;
            end
          endcase
        end
      end
      mcfd_pkg::ST_SINIT: begin
        rp_d     = off_q;
        pv_vld_d = 1'b0;
      end
      // stream bytes, look for the magic pair
      mcfd_pkg::ST_SRCH: begin
        if (pair_hit) begin
          start_d = rd_addr_q - PW'(1);
        end else begin
          if (rd_vld_q) begin
            pv_d     = rdata_q;
            pv_vld_d = 1'b1;
          end
          if (rp_q < fill_q) begin
            rd_vld_d  = 1'b1;
            rd_addr_d = rp_q;
            rp_d      = rp_q + PW'(1);
          end
        end
      end
      mcfd_pkg::ST_TAIL: begin
        mem_ra = fill_q[AW-1:0] - AW'(1);
        if (fill_q == '0) fill_d = '0;
      end
      // no pair left: keep a trailing first magic byte
      mcfd_pkg::ST_TAIL2: begin
        if (SW'(fill_q) > tail_lim) discard_d = discard_q + 32'(SW'(fill_q) - tail_lim);
        if (keep) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = cfg_i.sync_first;
        end
        fill_d = PW'(keep);
      end
      mcfd_pkg::ST_FOUND: begin
        if (start_q > off_q) begin
          discard_d = discard_q + 32'(start_q - off_q);
          if (!counted_q) resync_d = resync_q + 32'd1;
        end
        counted_d = 1'b0;
        rp_d      = start_q;
        di_d      = '0;
        crc_d     = mcfd_pkg::CRC_INIT;
      end
      // header bytes: CRC and field capture
      mcfd_pkg::ST_HDR: begin
        if (SW'(rp_q) < SW'(start_q) + HDR_S) begin
          rd_vld_d = 1'b1;
          rp_d     = rp_q + PW'(1);
        end
        if (rd_vld_q) begin
          crc_d = mcfd_pkg::crc32_byte(crc_q, rdata_q);
          di_d  = di_q + PW'(1);
          if (di_q == PW'(mcfd_pkg::OFS_VERSION)) ver_d = rdata_q;
          if (di_q == PW'(mcfd_pkg::OFS_TYPE))    typ_d = rdata_q;
          if (di_q == PW'(mcfd_pkg::OFS_FLAGS))   flg_d = rdata_q;
          if ((di_q >= PW'(mcfd_pkg::OFS_SEQ)) && (di_q < PW'(mcfd_pkg::OFS_SEQ + 4)))
            seq_d = {rdata_q, seq_q[31:8]};
          if ((di_q >= PW'(mcfd_pkg::OFS_LEN)) && (di_q < PW'(mcfd_pkg::OFS_LEN + 4)))
            plen_d = {rdata_q, plen_q[31:8]};
        end
      end
      mcfd_pkg::ST_CHK: begin
        if (len_bad) begin
          off_d     = start_q + PW'(2);
          counted_d = 1'b1;
          resync_d  = resync_q + 32'd1;
          discard_d = discard_q + 32'd2;
        end else if (short_frame) begin
          rp_d = start_q;
          di_d = '0;
        end
      end
      // payload CRC, then the received CRC word
      mcfd_pkg::ST_BODY: begin
        if (SW'(rp_q) < SW'(start_q) + frame_len) begin
          rd_vld_d = 1'b1;
          rp_d     = rp_q + PW'(1);
        end
        if (rd_vld_q) begin
          di_d = di_q + PW'(1);
          if (SW'(di_q) < HDR_S + SW'(plen6)) crc_d = mcfd_pkg::crc32_byte(crc_q, rdata_q);
          else                                crx_d = {rdata_q, crx_q[31:8]};
        end
      end
      mcfd_pkg::ST_CMPR: begin
        if (crc_ok) begin
          frames_d = frames_q + 32'd1;
          rp_d     = PW'(SW'(start_q) + HDR_S);
          di_d     = '0;
        end else begin
          off_d     = start_q + PW'(2);
          counted_d = 1'b1;
          crcfail_d = crcfail_q + 32'd1;
          resync_d  = resync_q + 32'd1;
          discard_d = discard_q + 32'd2;
        end
      end
      // one result beat per payload byte, or a single beat for an empty payload
      mcfd_pkg::ST_EMIT: begin
        res_o.version      = ver_q;
        res_o.msg_type     = typ_q;
        res_o.flag_bits    = flg_q;
        res_o.sequence_res = seq_q;
        res_o.payload_length = plen6;
        if (plen6 == '0) begin
          res_o.last = 1'b1;
          res_push_o = (res_free_i != '0);
        end else begin
          if ((SW'(rp_q) < SW'(start_q) + HDR_S + SW'(plen6))
              && (res_free_i >= mcfd_pkg::OQ_CW'(2))) begin
            rd_vld_d = 1'b1;
            rp_d     = rp_q + PW'(1);
          end
          if (rd_vld_q) begin
            res_push_o         = 1'b1;
            res_o.byte_index   = di_q[5:0];
            res_o.payload_byte = rdata_q;
            res_o.last         = emit_last;
            di_d               = di_q + PW'(1);
          end
        end
      end
      mcfd_pkg::ST_NEXT: begin
        if (next_done) fill_d = '0;
        else           off_d  = next_off[PW-1:0];
      end
      // move a partial frame to the buffer start
      mcfd_pkg::ST_COMP: begin
        if (rp_q < fill_q) begin
          rd_vld_d = 1'b1;
          rp_d     = rp_q + PW'(1);
        end
        if (rd_vld_q) begin
          mem_we = 1'b1;
          mem_wa = di_q[AW-1:0];
          mem_wd = rdata_q;
          di_d   = di_q + PW'(1);
        end
        if (scan_done) fill_d = fill_q - start_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcfd_pkg::ST_IDLE;
      fill_q <= '0;  off_q <= '0;  start_q <= '0;  counted_q <= 1'b0;
      rp_q <= '0;  di_q <= '0;  rd_addr_q <= '0;  rd_vld_q <= 1'b0;
      pv_q <= '0;  pv_vld_q <= 1'b0;
      ver_q <= '0;  typ_q <= '0;  flg_q <= '0;  seq_q <= '0;
      plen_q <= '0;  crc_q <= '0;  crx_q <= '0;
      frames_q <= '0;  resync_q <= '0;  discard_q <= '0;  crcfail_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;  off_q <= off_d;  start_q <= start_d;  counted_q <= counted_d;
      rp_q <= rp_d;  di_q <= di_d;  rd_addr_q <= rd_addr_d;  rd_vld_q <= rd_vld_d;
      pv_q <= pv_d;  pv_vld_q <= pv_vld_d;
      ver_q <= ver_d;  typ_q <= typ_d;  flg_q <= flg_d;  seq_q <= seq_d;
      plen_q <= plen_d;  crc_q <= crc_d;  crx_q <= crx_d;
      frames_q <= frames_d;  resync_q <= resync_d;
      discard_q <= discard_d;  crcfail_q <= crcfail_d;
    end
  end

  // buffer memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PW'(BUFFER_BYTES))
    else $error("fill count beyond buffer size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_free_i != '0))
    else $error("result pushed into a full queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == mcfd_pkg::ST_IDLE))
    else $error("command taken while busy");

  a_crc_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcfd_pkg::ST_CMPR && !crc_ok) |=> (state_q == mcfd_pkg::ST_SINIT))
    else $error("bad CRC did not restart the scan");

endmodule

// ----- rtl/magic_crc_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// magic_crc_frame_deframer
// Hunts a two-byte magic in a byte stream, checks header length and CRC-32,
// and emits each good frame as payload-byte result beats.
// ----------------------------------------------------------------------------
//  channel  | handshake              | beat
//  ---------+------------------------+---------------------------------------
//  input    | push_i / full_o        | op_i, data_byte_i, counter_select_i
//  result   | pop_i / empty_o        | kind_o .. counter_value_o
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata
//
// An input beat enters a two-entry queue; the back end takes one command at a
// time. For each data byte it rescans the buffered bytes, reads the header,
// payload and CRC of each frame it checks, and reads each payload byte again
// to emit it, all through the single read port of the frame buffer. Reset
// clears all control state; the buffer needs no clearing. A full result queue
// stalls emission.
// ----------------------------------------------------------------------------
module magic_crc_frame_deframer #(
  parameter int BUFFER_BYTES = 64,
  parameter int HEADER_BYTES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [1:0]  counter_select_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        kind_o,
  output logic [7:0]  version_o,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  flag_bits_o,
  output logic [31:0] sequence_res_o,
  output logic [5:0]  payload_length_o,
  output logic [5:0]  byte_index_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  output logic [31:0] counter_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] sync0_q, sync0_d, sync1_q, sync1_d;
  logic [5:0] lim_q, lim_d;
  logic       cfg_wr;
  mcfd_pkg::cfg_t cfg;

  logic           cmd_valid, cmd_pop, res_push;
  mcfd_pkg::cmd_t cmd;
  mcfd_pkg::res_t res_in, res_out;
  logic [mcfd_pkg::OQ_CW-1:0] res_free;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    sync0_d = sync0_q;
    sync1_d = sync1_q;
    lim_d   = lim_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        mcfd_pkg::REG_SYNC_FIRST:  sync0_d = pwdata[7:0];
        mcfd_pkg::REG_SYNC_SECOND: sync1_d = pwdata[7:0];
        mcfd_pkg::REG_PAYLOAD_LIM: lim_d   = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mcfd_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync0_q};
      mcfd_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync1_q};
      mcfd_pkg::REG_PAYLOAD_LIM: prdata = {26'd0, lim_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync0_q <= '0;
      sync1_q <= '0;
      lim_q   <= mcfd_pkg::PAYLOAD_LIM_RST;
    end else begin
      sync0_q <= sync0_d;
      sync1_q <= sync1_d;
      lim_q   <= lim_d;
    end
  end

  always_comb begin
    cfg.sync_first  = sync0_q;
    cfg.sync_second = sync1_q;
    cfg.limit       = lim_q;
  end

  mcfd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .counter_select_i (counter_select_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  mcfd_engine #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_free_i  (res_free)
  );

  mcfd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .free_o  (res_free),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .res_o   (res_out)
  );

  // result fields
  assign kind_o           = res_out.kind;
  assign version_o        = res_out.version;
  assign msg_type_o       = res_out.msg_type;
  assign flag_bits_o      = res_out.flag_bits;
  assign sequence_res_o   = res_out.sequence_res;
  assign payload_length_o = res_out.payload_length;
  assign byte_index_o     = res_out.byte_index;
  assign payload_byte_o   = res_out.payload_byte;
  assign last_o           = res_out.last;
  assign counter_value_o  = res_out.counter_value;

endmodule
